FILE: src/lkvc_pkg.sv
// Shared constants and types for the LRU key-value cache.
// No dependencies; the top level and the testbench refer to it by scoped names.
`default_nettype none

package lkvc_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ENTRY_W     = KEY_W + VAL_W;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = IDX_W + 1;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(NUM_ENTRIES);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: src/lkvc_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing; the width and depth come from its parameters.
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and on lkvc_ram, which holds the keys and values.
//
//   channel  handshake                 payload
//   in_      start / busy              in_command, in_lookup_key, in_store_value
//   out_     out_valid (one cycle)     out_hit, out_read_value
//   cfg_     cfg_valid / cfg_ready     cfg_capacity_in_use
//
// Each request holds busy through a scan state and a decide state. The scan
// sweeps the key/value RAM one entry per cycle, comparing each entry's
// registered read data with the key; the decide state writes back and updates
// recency. The result strobe follows in the next cycle, together with busy
// falling, and a new request may start in that same cycle, so requests never
// overlap. Capacity writes wait while busy.
// Reset (synchronous, rst_n low) clears valid marks, ranks, the entry count
// and the capacity register (to 16); the RAM itself is never cleared.
// The receiver cannot stall.
`default_nettype none

module lru_key_value_cache (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_command,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]  in_lookup_key,
  input  wire logic signed [lkvc_pkg::VAL_W-1:0]  in_store_value,
  // result channel
  output logic                                    out_valid,
  output logic                                    out_hit,
  output logic signed      [lkvc_pkg::VAL_W-1:0]  out_read_value,
  // configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [lkvc_pkg::CAP_W-1:0]  cfg_capacity_in_use
);

  localparam int N = lkvc_pkg::NUM_ENTRIES;

  // control state
  lkvc_pkg::state_t               state_r, state_nxt;
  logic [lkvc_pkg::CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                           cmp_en_r;
  logic [lkvc_pkg::IDX_W-1:0]     cmp_idx_r;
  logic                           found_r;
  logic [lkvc_pkg::IDX_W-1:0]     slot_r;
  logic [N-1:0]                   valid_r, valid_nxt;
  logic [lkvc_pkg::RANK_W-1:0]    rank_r   [N];
  logic [lkvc_pkg::RANK_W-1:0]    rank_nxt [N];
  logic [lkvc_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [lkvc_pkg::CAP_W-1:0]     cap_r;
  logic                           out_valid_r;

  // payload registers
  logic                           cmd_r;
  logic [lkvc_pkg::KEY_W-1:0]     key_r;
  logic [lkvc_pkg::VAL_W-1:0]     val_r;
  logic [lkvc_pkg::VAL_W-1:0]     hit_val_r;
  logic                           out_hit_r;
  logic [lkvc_pkg::VAL_W-1:0]     out_read_value_r;

  // RAM port
  logic                           ram_we;
  logic [lkvc_pkg::IDX_W-1:0]     ram_addr;
  logic [lkvc_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [lkvc_pkg::KEY_W-1:0]     rd_key;
  logic [lkvc_pkg::VAL_W-1:0]     rd_val;
  logic                           key_match;

  // decision
  logic [lkvc_pkg::CNT_W-1:0]     eff_cap;
  logic                           do_fill;
  logic [lkvc_pkg::IDX_W-1:0]     free_idx;
  logic [lkvc_pkg::IDX_W-1:0]     victim_idx;
  logic [lkvc_pkg::IDX_W-1:0]     tgt_idx;
  logic [lkvc_pkg::RANK_W-1:0]    oldest_rank;

  lkvc_ram #(
    .WIDTH (lkvc_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   ({key_r, val_r}),
    .rdata_r (ram_rdata)
  );

  assign busy      = (state_r != lkvc_pkg::ST_IDLE);
  // Hold capacity writes off while a request is in flight.
  assign cfg_ready = !busy;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

  assign rd_key    = ram_rdata[lkvc_pkg::ENTRY_W-1:lkvc_pkg::VAL_W];
  assign rd_val    = ram_rdata[lkvc_pkg::VAL_W-1:0];
  assign key_match = cmp_en_r && valid_r[cmp_idx_r] && (rd_key == key_r);

  // Write back only in the decide cycle; reads never overlap a write, so
  // the sequencing itself serves as the interlock.
  assign ram_we   = (state_r == lkvc_pkg::ST_DECIDE) && (cmd_r == lkvc_pkg::CMD_PUT);
  assign ram_addr = (state_r == lkvc_pkg::ST_DECIDE) ? tgt_idx
                                                     : scan_cnt_r[lkvc_pkg::IDX_W-1:0];

  // Clamp capacity: zero acts as one, anything above the table size as the size.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkvc_pkg::CNT_W'(1);
    end else if (lkvc_pkg::CNT_W'(cap_r) > lkvc_pkg::CNT_W'(N)) begin
      eff_cap = lkvc_pkg::CNT_W'(N);
    end else begin
      eff_cap = lkvc_pkg::CNT_W'(cap_r);
    end
  end

  // Least recent valid entry holds rank count-1 (ranks form a permutation).
  assign oldest_rank = lkvc_pkg::RANK_W'(count_r - lkvc_pkg::CNT_W'(1));
  assign do_fill = !found_r && (count_r < eff_cap);

  always_comb begin
    free_idx   = '0;
    victim_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = lkvc_pkg::IDX_W'(i);
      end
      if (valid_r[i] && (rank_r[i] == oldest_rank)) begin
        victim_idx = lkvc_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (found_r) begin
      tgt_idx = slot_r;
    end else if (do_fill) begin
      tgt_idx = free_idx;
    end else begin
      tgt_idx = victim_idx;
    end
  end

  // Recency update, all ranks in parallel.
  always_comb begin
    logic [lkvc_pkg::RANK_W-1:0] r;
    r         = rank_r[tgt_idx];
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (state_r == lkvc_pkg::ST_DECIDE) begin
      if ((cmd_r == lkvc_pkg::CMD_PUT) && do_fill) begin
        // age every valid entry, then insert the new one as most recent
        for (int i = 0; i < N; i++) begin
          if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + lkvc_pkg::RANK_W'(1);
          end
        end
        rank_nxt[free_idx]  = '0;
        valid_nxt[free_idx] = 1'b1;
        count_nxt           = count_r + lkvc_pkg::CNT_W'(1);
      end else if (found_r || (cmd_r == lkvc_pkg::CMD_PUT)) begin
        // touch: entries more recent than the target move one step older
        for (int i = 0; i < N; i++) begin
          if (valid_r[i] && (rank_r[i] < r)) begin
            rank_nxt[i] = rank_r[i] + lkvc_pkg::RANK_W'(1);
          end
        end
        rank_nxt[tgt_idx] = '0;
      end
    end
  end

  // Sequencer: idle -> scan -> decide -> idle.
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        scan_cnt_nxt = '0;
        if (start) begin
          state_nxt = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + lkvc_pkg::CNT_W'(1);
        if (scan_cnt_r == lkvc_pkg::CNT_W'(N)) begin
          state_nxt = lkvc_pkg::ST_DECIDE;
        end
      end
      lkvc_pkg::ST_DECIDE: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkvc_pkg::ST_IDLE;
      scan_cnt_r  <= '0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      cap_r       <= lkvc_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == lkvc_pkg::ST_DECIDE);
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      // compare the entry read in the previous cycle
      cmp_en_r <= (state_r == lkvc_pkg::ST_SCAN) && (scan_cnt_r < lkvc_pkg::CNT_W'(N));
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_in_use;
      end
      if ((state_r == lkvc_pkg::ST_IDLE) && start) begin
        found_r <= 1'b0;
      end else if (key_match) begin
        found_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_cnt_r[lkvc_pkg::IDX_W-1:0];
    if ((state_r == lkvc_pkg::ST_IDLE) && start) begin
      cmd_r <= in_command;
      key_r <= in_lookup_key;
      val_r <= in_store_value;
    end
    // first matching entry wins
    if (key_match && !found_r) begin
      slot_r    <= cmp_idx_r;
      hit_val_r <= rd_val;
    end
    if (state_r == lkvc_pkg::ST_DECIDE) begin
      out_hit_r        <= found_r;
      out_read_value_r <= (found_r && (cmd_r == lkvc_pkg::CMD_GET)) ? hit_val_r : '0;
    end
  end

  // The valid marks and the entry count always agree.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("entry count disagrees with valid marks");

  // Every decide cycle is followed by a result strobe.
  a_strobe_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkvc_pkg::ST_DECIDE) |=> out_valid_r)
    else $error("decide cycle without result strobe");

  // Eviction only ever happens with at least one valid entry present.
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == lkvc_pkg::ST_DECIDE) && (cmd_r == lkvc_pkg::CMD_PUT) && !found_r && !do_fill)
      |-> (count_r != '0))
    else $error("eviction with empty cache");

  // The RAM is never written outside the decide cycle.
  a_write_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == lkvc_pkg::ST_DECIDE) && !out_valid_r)
    else $error("RAM write outside decide");

endmodule

`default_nettype wire

FILE: bench/lru_key_value_cache_tb.sv
// Self-checking testbench for lru_key_value_cache: directed table, then random get/put traffic.
// Depends on lkvc_pkg and the RTL only; it keeps its own LRU predictor of the cache contents.
`default_nettype none

module lru_key_value_cache_tb;

  localparam int TIMEOUT_UNITS = 6_000_000;
  localparam int RANDOM_PER_PHASE = 54;

  // One result as the block shows it on the out_ ports.
  typedef struct packed {
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] read_value;
  } cache_result_t;

  // A row of the directed table: a request or a capacity write.
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic                       command;
    logic [lkvc_pkg::KEY_W-1:0] key;
    logic [lkvc_pkg::VAL_W-1:0] data;       // store value, or the new capacity on a config row
    logic                       fixed;      // 1: check against the typed-in result below
    logic                       exp_hit;
    logic [lkvc_pkg::VAL_W-1:0] exp_value;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic signed [lkvc_pkg::KEY_W-1:0] in_lookup_key;
  logic signed [lkvc_pkg::VAL_W-1:0] in_store_value;
  logic out_valid;
  logic out_hit;
  logic signed [lkvc_pkg::VAL_W-1:0] out_read_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0] cfg_capacity_in_use;

  // Predictor copy of the cache: keys, values, valid marks, LRU ranks (0 = newest).
  logic [lkvc_pkg::KEY_W-1:0] shadow_keys   [lkvc_pkg::NUM_ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] shadow_values [lkvc_pkg::NUM_ENTRIES];
  bit                         shadow_valid  [lkvc_pkg::NUM_ENTRIES];
  int unsigned                shadow_rank   [lkvc_pkg::NUM_ENTRIES];
  int unsigned                shadow_count;
  logic [lkvc_pkg::CAP_W-1:0] shadow_capacity;

  cache_result_t expected_results [$];

  int errors;
  int requests_sent;
  int gets_sent;
  int results_seen;
  int hits_seen;
  int evictions;
  int capacity_writes;

  step_row_t directed_steps [0:20];
  logic [lkvc_pkg::CAP_W-1:0] phase_capacity [0:8];

  lru_key_value_cache u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_lookup_key       (in_lookup_key),
    .in_store_value      (in_store_value),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(TIMEOUT_UNITS);
    $display("lru_key_value_cache test failed");
    $finish;
  end

  // Move a valid entry to the front: every valid entry newer than it ages by one.
  function automatic void make_most_recent(input int slot);
    int unsigned old_rank;
    old_rank = shadow_rank[slot];
    for (int i = 0; i < lkvc_pkg::NUM_ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
    end
    shadow_rank[slot] = 0;
  endfunction

  // Apply one request to the shadow cache and return what the block must answer.
  function automatic cache_result_t lru_predict(input logic command,
                                                input logic [lkvc_pkg::KEY_W-1:0] key,
                                                input logic [lkvc_pkg::VAL_W-1:0] data);
    cache_result_t res;
    int slot;
    int free_slot;
    int victim;
    int unsigned limit;
    slot = -1;
    free_slot = -1;
    victim = -1;
    // Capacity 0 behaves as 1; anything above the entry count behaves as full size.
    limit = (shadow_capacity == 0) ? 1 :
            (shadow_capacity > lkvc_pkg::NUM_ENTRIES) ? lkvc_pkg::NUM_ENTRIES : shadow_capacity;
    for (int i = 0; i < lkvc_pkg::NUM_ENTRIES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_keys[i] == key) slot = i;
    end
    res.hit = (slot >= 0);
    res.read_value = '0;
    if (command == lkvc_pkg::CMD_GET) begin
      if (slot >= 0) begin
        res.read_value = shadow_values[slot];
        make_most_recent(slot);
      end
    end else if (slot >= 0) begin
      shadow_values[slot] = data;
      make_most_recent(slot);
    end else begin
      if (shadow_count < limit) begin
        for (int i = 0; i < lkvc_pkg::NUM_ENTRIES; i++) begin
          if (free_slot < 0 && !shadow_valid[i]) free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < lkvc_pkg::NUM_ENTRIES; i++) begin
          if (shadow_valid[i]) shadow_rank[i]++;
        end
        shadow_valid[free_slot]  = 1'b1;
        shadow_keys[free_slot]   = key;
        shadow_values[free_slot] = data;
        shadow_rank[free_slot]   = 0;
        shadow_count++;
      end else begin
        // Full (or capacity lowered below the count): overwrite the oldest entry.
        for (int i = 0; i < lkvc_pkg::NUM_ENTRIES; i++) begin
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
            victim = i;
        end
        if (victim >= 0) begin
          shadow_keys[victim]   = key;
          shadow_values[victim] = data;
          make_most_recent(victim);
          evictions++;
        end
      end
    end
    return res;
  endfunction

  // Random idle after a request: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one request and hold it until the block takes it (start high, busy low).
  task automatic send_request(input logic command, input logic [lkvc_pkg::KEY_W-1:0] key,
                              input logic [lkvc_pkg::VAL_W-1:0] data, input logic fixed,
                              input cache_result_t typed);
    cache_result_t predicted;
    start          <= 1'b1;
    in_command     <= command;
    in_lookup_key  <= key;
    in_store_value <= data;
    do @(posedge clk); while (busy);
    predicted = lru_predict(command, key, data);
    expected_results.push_back(fixed ? typed : predicted);
    requests_sent++;
    if (command == lkvc_pkg::CMD_GET) gets_sent++;
  endtask

  // Drop start for a random gap, or keep it high so the next request follows directly.
  task automatic idle_after(input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain: stop sending and wait for every outstanding result plus a few cycles.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] capacity);
    cfg_valid           <= 1'b1;
    cfg_capacity_in_use <= capacity;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_capacity = capacity;
    capacity_writes++;
  endtask

  // Random traffic over a small key pool, so hits, updates and evictions all occur.
  task automatic run_random_phase(input int n_items, input bit no_gaps);
    logic [lkvc_pkg::KEY_W-1:0] key_pool [$];
    int pool_size;
    logic command;
    logic [lkvc_pkg::KEY_W-1:0] key;
    cache_result_t unused;
    unused = '0;
    pool_size = $urandom_range(2, 24);
    for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
    for (int n = 0; n < n_items; n++) begin
      command = $urandom_range(0, 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET;
      // Mostly pool keys; a few fresh ones to hit the miss path on arbitrary bits.
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
      send_request(command, key, $urandom, 1'b0, unused);
      idle_after(no_gaps);
    end
  endtask

  // Result checker: the block cannot be stalled, so take every strobe at the edge that ends it.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_hit) hits_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: hit=%0b read_value=%h",
                 $time, out_hit, out_read_value);
      end else begin
        want = expected_results.pop_front();
        if (out_hit !== want.hit) begin
          errors++;
          $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, out_hit);
        end
        if (out_read_value !== want.read_value) begin
          errors++;
          $display("%0t: read_value mismatch: expected %h, actual %h",
                   $time, want.read_value, out_read_value);
        end
      end
    end
  end

  initial begin
    cache_result_t typed;
    step_row_t row;

    // Directed table. Typed-in results only where they are obvious; the rest use the predictor.
    directed_steps = '{
      // get on an empty cache misses with zero data
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      // extremes of key and value
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h7FFF_FFFF},
      // stored -1 must come back as a hit, distinct from a miss
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      // key zero never written: must miss, as no valid entry holds it
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      // put that hits overwrites and answers zero data
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h5555_5555, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h5555_5555},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'hAAAA_AAAA, 1'b1, 1'b1, 32'h0000_0000},
      // capacity zero (acts as one) while four entries are held: puts now evict
      '{ROW_CFG, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h1234_5678, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_0009, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      // capacity 31 saturates at the full size: free entries fill again
      '{ROW_CFG, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_55AA, 32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_55AA, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
    };
    // Phase capacities: defaults, extremes, out of range, and lowering below the count.
    phase_capacity = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd16, 5'd8, 5'd12};
    phase_capacity[8] = lkvc_pkg::CAP_W'($urandom_range(0, 31));

    errors = 0;
    requests_sent = 0;
    gets_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    evictions = 0;
    capacity_writes = 0;

    // Clear the shadow cache: valid marks, ranks and count as reset clears the block's.
    for (int i = 0; i < lkvc_pkg::NUM_ENTRIES; i++) begin
      shadow_keys[i]   = '0;
      shadow_values[i] = '0;
      shadow_valid[i]  = 1'b0;
      shadow_rank[i]   = 0;
    end
    shadow_count = 0;
    shadow_capacity = lkvc_pkg::CAP_RESET;

    // Hold every input at a known value through reset.
    rst_n               <= 1'b0;
    start               <= 1'b0;
    in_command          <= lkvc_pkg::CMD_GET;
    in_lookup_key       <= '0;
    in_store_value      <= '0;
    cfg_valid           <= 1'b0;
    cfg_capacity_in_use <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Walk the directed table; config rows wait for the cache to go idle first.
    for (int r = 0; r < $size(directed_steps); r++) begin
      row = directed_steps[r];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_capacity(row.data[lkvc_pkg::CAP_W-1:0]);
      end else begin
        typed.hit = row.exp_hit;
        typed.read_value = row.exp_value;
        send_request(row.command, row.key, row.data, row.fixed, typed);
        idle_after(1'b0);
      end
    end

    // Random phases, each under its own capacity; in two phases requests run back to back with no idling.
    for (int p = 0; p < $size(phase_capacity); p++) begin
      drain_results();
      write_capacity(phase_capacity[p]);
      run_random_phase(RANDOM_PER_PHASE, (p == 2 || p == 6));
    end

    // Wait out every outstanding result, then a little longer for strays.
    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d requests (%0d gets), %0d results, %0d hits, %0d evictions,",
             requests_sent, gets_sent, results_seen, hits_seen, evictions);
    $display("across %0d capacity settings including 0, 1, 16 and 31.", capacity_writes);
    if (errors == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
